// ===== hw/rtl/gww_pkg.sv =====
// Shared types, codes and character helpers for the caption word-wrap cell generator.
package gww_pkg;

   localparam int CHAR_W    = 16;
   localparam int ATTR_W    = 16;
   localparam int ACCEL_W   = 12;
   localparam int LINE_W    = 8;
   localparam int COL_W     = 5;
   localparam int REG_IDX_W = 3;

   // Character codes that steer the wrap
   localparam logic [CHAR_W-1:0] CHAR_CR    = 16'h000D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 16'h000A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;

   // Highlight attribute: keep the background nibble, force bright foreground
   localparam logic [ATTR_W-1:0] ATTR_KEEP_MASK = 16'h00F0;
   localparam logic [ATTR_W-1:0] ATTR_HI_SET    = 16'h000F;

   // Alignment codes
   localparam logic [1:0] ALIGN_CENTER = 2'd1;
   localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TEXT_ALIGN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL_ENABLE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL_POS    = 3'd4;

   // Register reset values
   localparam logic [5:0]         RST_LINE_WIDTH = 6'd32;
   localparam logic [ATTR_W-1:0]  RST_TEXT_ATTR  = 16'h0007;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_USE,
      ST_EMIT_RD,
      ST_EMIT_USE,
      ST_SKIP_RD,
      ST_SKIP_USE,
      ST_DROP,
      ST_END,
      ST_FLUSH
   } gww_state_type;

   function automatic logic is_hard(input logic [CHAR_W-1:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_swallow(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

// ===== hw/rtl/gww_line_buf.sv =====
// Circular line buffer: one write and one registered read per cycle, addressed from the head.
module gww_line_buf #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH+1)-1:0]        wr_rel,
   input  logic [gww_pkg::CHAR_W-1:0]        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] head,
   input  logic [$clog2(DEPTH+1)-1:0]        rd_rel,
   output logic [gww_pkg::CHAR_W-1:0]        rd_data
);
   import gww_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = CW + 1;

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;

   // Head-relative index to physical entry, one wrap at most
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] rel);
      logic [SW-1:0] sum;
      sum = SW'(h) + SW'(rel);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return AW'(sum);
   endfunction

   assign wr_addr = phys(head, wr_rel);
   assign rd_addr = phys(head, rd_rel);

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/greedy_word_wrap_cells.sv =====
// Top level of the caption word-wrap cell generator: registers, sequencer and result path.
//
// Caption characters enter one transfer at a time; the block buffers one display line
// and sends it out as text cells with aligned column, line index and attribute. While
// an item is being worked on req_stall stays high. A character that only joins the line
// passes accept, check, end test and flush. A line that is sent takes a read and a use
// step per cell. A break at the width adds a read and a use step per position of the
// backward space search, per swallowed blank after the cut and for the entry that ends
// that run when one is left, and a drop and a recheck, all set by the single read port
// of the line buffer that the sequencer walks one entry at a time. The last cell of an
// item leaves through a one-entry holding stage so run_last and caption_done are known
// when it is sent; an output register decouples rsp_stall from the sequencer.
module greedy_word_wrap_cells #(
   parameter int MAX_WIDTH   = 32,
   parameter int MAX_CAPTION = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // caption characters
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gww_pkg::CHAR_W-1:0]    req_text_char,
   input  logic                          req_text_end,
   // text cells
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gww_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [gww_pkg::COL_W-1:0]     rsp_cell_column,
   output logic [gww_pkg::LINE_W-1:0]    rsp_cell_line,
   output logic [gww_pkg::ATTR_W-1:0]    rsp_cell_attr,
   output logic                          rsp_line_done,
   output logic                          rsp_caption_done,
   output logic                          rsp_run_last,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [4:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import gww_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW = CW + 1;
   localparam int PW = $clog2(MAX_CAPTION);
   localparam int XW = (PW > ACCEL_W) ? PW : ACCEL_W;
   localparam logic [CW-1:0] WIDTH_MAX = CW'(MAX_WIDTH);
   localparam logic [PW-1:0] POS_LAST  = PW'(MAX_CAPTION - 1);

   // Configuration registers
   logic [5:0]         cfg_width_ff,  cfg_width_in;
   logic [1:0]         cfg_align_ff,  cfg_align_in;
   logic [ATTR_W-1:0]  cfg_attr_ff,   cfg_attr_in;
   logic               cfg_acc_en_ff, cfg_acc_en_in;
   logic [ACCEL_W-1:0] cfg_acc_pos_ff, cfg_acc_pos_in;

   // Sequencer and stream state
   gww_state_type      state_ff, state_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               end_ff, end_in;
   logic [PW-1:0]      char_pos_ff, char_pos_in;
   logic [PW-1:0]      caption_pos_ff, caption_pos_in;
   logic [PW-1:0]      start_pos_ff, start_pos_in;
   logic [PW-1:0]      cur_pos_ff, cur_pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;
   logic               skipping_ff, skipping_in;
   logic [LINE_W-1:0]  line_num_ff, line_num_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      len_ff, len_in;
   logic               brk_ff, brk_in;

   // Holding stage for the newest cell
   logic               pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic [COL_W-1:0]   pend_col_ff, pend_col_in;
   logic [LINE_W-1:0]  pend_line_ff, pend_line_in;
   logic [ATTR_W-1:0]  pend_attr_ff, pend_attr_in;
   logic               pend_ldone_ff, pend_ldone_in;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [LINE_W-1:0]  out_line_ff, out_line_in;
   logic [ATTR_W-1:0]  out_attr_ff, out_attr_in;
   logic               out_ldone_ff, out_ldone_in;
   logic               out_cdone_ff, out_cdone_in;
   logic               out_last_ff, out_last_in;

   // Buffer port
   logic               wr_en;
   logic [CHAR_W-1:0]  rd_data;

   // Shared helpers
   logic [CW-1:0]      eff_w;
   logic               need_break;
   logic               char_swallow;
   logic               char_hard;
   logic               rd_swallow;
   logic               out_free;
   logic               can_push;
   logic [CW-1:0]      idx_inc;
   logic               last_cell;
   logic [PW-1:0]      cur_pos_inc;
   logic [PW-1:0]      caption_pos_inc;
   logic [CW-1:0]      len_gap;
   logic [CW-1:0]      col0;
   logic [COL_W-1:0]   cell_col;
   logic               accel_hit;
   logic [ATTR_W-1:0]  cell_attr;
   logic [SW-1:0]      head_sum;
   logic [AW-1:0]      head_wrap;
   logic [LINE_W-1:0]  line_inc;
   logic               cfg_wr;
   logic [REG_IDX_W-1:0] cfg_idx;

   gww_line_buf #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_rel (count_ff),
      .wr_data(char_ff),
      .head   (head_ff),
      .rd_rel (idx_ff),
      .rd_data(rd_data)
   );

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_width_in   = cfg_width_ff;
      cfg_align_in   = cfg_align_ff;
      cfg_attr_in    = cfg_attr_ff;
      cfg_acc_en_in  = cfg_acc_en_ff;
      cfg_acc_pos_in = cfg_acc_pos_ff;
      if (cfg_wr) begin
         unique case (cfg_idx)
            REG_LINE_WIDTH:   cfg_width_in   = csr_pwdata[5:0];
            REG_TEXT_ALIGN:   cfg_align_in   = csr_pwdata[1:0];
            REG_TEXT_ATTR:    cfg_attr_in    = csr_pwdata[ATTR_W-1:0];
            REG_ACCEL_ENABLE: cfg_acc_en_in  = csr_pwdata[0];
            REG_ACCEL_POS:    cfg_acc_pos_in = csr_pwdata[ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_LINE_WIDTH:   csr_prdata = 32'(cfg_width_ff);
         REG_TEXT_ALIGN:   csr_prdata = 32'(cfg_align_ff);
         REG_TEXT_ATTR:    csr_prdata = 32'(cfg_attr_ff);
         REG_ACCEL_ENABLE: csr_prdata = 32'(cfg_acc_en_ff);
         REG_ACCEL_POS:    csr_prdata = 32'(cfg_acc_pos_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective width, clamped to 1..MAX_WIDTH
   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_w = CW'(1);
      end else if (cfg_width_ff > 6'(MAX_WIDTH)) begin
         eff_w = WIDTH_MAX;
      end else begin
         eff_w = CW'(cfg_width_ff);
      end
   end

   assign need_break   = (count_ff != '0) && (count_ff >= eff_w);
   assign char_swallow = is_swallow(char_ff);
   assign char_hard    = is_hard(char_ff);
   assign rd_swallow   = is_swallow(rd_data);
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign can_push     = !pend_valid_ff || out_free;
   assign idx_inc      = idx_ff + CW'(1);
   assign last_cell    = (idx_inc == len_ff);
   assign cur_pos_inc  = (cur_pos_ff == POS_LAST) ? '0 : cur_pos_ff + PW'(1);
   assign caption_pos_inc = (caption_pos_ff == POS_LAST) ? '0 : caption_pos_ff + PW'(1);
   assign line_inc     = (line_num_ff == '1) ? line_num_ff : line_num_ff + LINE_W'(1);

   // Column of the current cell
   assign len_gap = eff_w - len_ff;
   always_comb begin
      col0 = '0;
      if (len_ff <= eff_w) begin
         case (cfg_align_ff)
            ALIGN_RIGHT:  col0 = len_gap;
            ALIGN_CENTER: col0 = len_gap >> 1;
            default:      col0 = '0;
         endcase
      end
   end
   assign cell_col = COL_W'(col0 + idx_ff);

   // Accelerator highlight
   assign accel_hit = cfg_acc_en_ff && (XW'(cur_pos_ff) == XW'(cfg_acc_pos_ff));
   assign cell_attr = accel_hit ? ((cfg_attr_ff & ATTR_KEEP_MASK) | ATTR_HI_SET) : cfg_attr_ff;

   // Head after dropping idx entries
   always_comb begin
      head_sum = SW'(head_ff) + SW'(idx_ff);
      if (head_sum >= SW'(MAX_WIDTH)) begin
         head_wrap = AW'(head_sum - SW'(MAX_WIDTH));
      end else begin
         head_wrap = AW'(head_sum);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (need_break) begin
               state_in = (eff_w == CW'(1)) ? ST_EMIT_RD : ST_SCAN_RD;
            end else if (skipping_ff && char_swallow) begin
               state_in = ST_END;
            end else if (char_hard && (count_ff != '0)) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_END;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_USE;
         ST_SCAN_USE: begin
            if ((rd_data == CHAR_SPACE) || (idx_ff == CW'(1))) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD:  state_in = ST_EMIT_USE;
         ST_EMIT_USE: begin
            if (can_push) begin
               if (!last_cell) begin
                  state_in = ST_EMIT_RD;
               end else if (!brk_ff) begin
                  state_in = ST_END;
               end else if (len_ff < count_ff) begin
                  state_in = ST_SKIP_RD;
               end else begin
                  state_in = ST_DROP;
               end
            end
         end
         ST_SKIP_RD:  state_in = ST_SKIP_USE;
         ST_SKIP_USE: begin
            if (rd_swallow && (idx_inc < count_ff)) begin
               state_in = ST_SKIP_RD;
            end else begin
               state_in = ST_DROP;
            end
         end
         ST_DROP: state_in = ST_CHECK;
         ST_END: begin
            state_in = (end_ff && (count_ff != '0)) ? ST_EMIT_RD : ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer
   always_comb begin
      char_in        = char_ff;
      end_in         = end_ff;
      char_pos_in    = char_pos_ff;
      caption_pos_in = caption_pos_ff;
      start_pos_in   = start_pos_ff;
      cur_pos_in     = cur_pos_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      skipping_in    = skipping_ff;
      line_num_in    = line_num_ff;
      idx_in         = idx_ff;
      len_in         = len_ff;
      brk_in         = brk_ff;
      wr_en          = 1'b0;
      pend_valid_in  = pend_valid_ff;
      pend_char_in   = pend_char_ff;
      pend_col_in    = pend_col_ff;
      pend_line_in   = pend_line_ff;
      pend_attr_in   = pend_attr_ff;
      pend_ldone_in  = pend_ldone_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_char_in    = out_char_ff;
      out_col_in     = out_col_ff;
      out_line_in    = out_line_ff;
      out_attr_in    = out_attr_ff;
      out_ldone_in   = out_ldone_ff;
      out_cdone_in   = out_cdone_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               char_in        = req_text_char;
               end_in         = req_text_end;
               char_pos_in    = caption_pos_ff;
               caption_pos_in = caption_pos_inc;
            end
         end
         ST_CHECK: begin
            if (need_break) begin
               // Line full: search back for a space, or cut at the width
               cur_pos_in = start_pos_ff;
               brk_in     = 1'b1;
               if (eff_w == CW'(1)) begin
                  len_in = eff_w;
                  idx_in = '0;
               end else begin
                  idx_in = eff_w - CW'(1);
               end
            end else if (skipping_ff && char_swallow) begin
               // dropped blank after a break, a hard line end or at the caption start
            end else if (char_hard) begin
               skipping_in = 1'b1;
               if (count_ff != '0) begin
                  len_in     = count_ff;
                  idx_in     = '0;
                  cur_pos_in = start_pos_ff;
                  brk_in     = 1'b0;
               end
            end else if (count_ff < WIDTH_MAX) begin
               // Append to the line
               wr_en       = 1'b1;
               count_in    = count_ff + CW'(1);
               skipping_in = 1'b0;
               if (count_ff == '0) start_pos_in = char_pos_ff;
            end
         end
         ST_SCAN_USE: begin
            if (rd_data == CHAR_SPACE) begin
               len_in     = idx_ff;
               idx_in     = '0;
               cur_pos_in = start_pos_ff;
            end else if (idx_ff == CW'(1)) begin
               len_in     = eff_w;
               idx_in     = '0;
               cur_pos_in = start_pos_ff;
            end else begin
               idx_in = idx_ff - CW'(1);
            end
         end
         ST_EMIT_USE: begin
            if (can_push) begin
               // Older held cell moves to the output register
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_char_in  = pend_char_ff;
                  out_col_in   = pend_col_ff;
                  out_line_in  = pend_line_ff;
                  out_attr_in  = pend_attr_ff;
                  out_ldone_in = pend_ldone_ff;
                  out_cdone_in = 1'b0;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_char_in  = rd_data;
               pend_col_in   = cell_col;
               pend_line_in  = line_num_ff;
               pend_attr_in  = cell_attr;
               pend_ldone_in = last_cell;
               cur_pos_in    = cur_pos_inc;
               idx_in        = idx_inc;
               if (last_cell) begin
                  line_num_in = line_inc;
                  if (!brk_ff) begin
                     count_in = '0;
                     head_in  = '0;
                  end
               end
            end
         end
         ST_SKIP_USE: begin
            if (rd_swallow) begin
               idx_in     = idx_inc;
               cur_pos_in = cur_pos_inc;
            end
         end
         ST_DROP: begin
            count_in     = count_ff - idx_ff;
            head_in      = head_wrap;
            start_pos_in = cur_pos_ff;
            skipping_in  = (count_ff == idx_ff);
         end
         ST_END: begin
            if (end_ff && (count_ff != '0)) begin
               len_in     = count_ff;
               idx_in     = '0;
               cur_pos_in = start_pos_ff;
               brk_in     = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_char_in  = pend_char_ff;
                  out_col_in   = pend_col_ff;
                  out_line_in  = pend_line_ff;
                  out_attr_in  = pend_attr_ff;
                  out_ldone_in = pend_ldone_ff;
                  out_cdone_in = end_ff;
                  out_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               // Caption finished: stream state back to its start values
               if (end_ff) begin
                  count_in       = '0;
                  head_in        = '0;
                  start_pos_in   = '0;
                  caption_pos_in = '0;
                  skipping_in    = 1'b1;
                  line_num_in    = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff   <= RST_LINE_WIDTH;
         cfg_align_ff   <= '0;
         cfg_attr_ff    <= RST_TEXT_ATTR;
         cfg_acc_en_ff  <= 1'b0;
         cfg_acc_pos_ff <= '0;
         state_ff       <= ST_IDLE;
         caption_pos_ff <= '0;
         start_pos_ff   <= '0;
         count_ff       <= '0;
         head_ff        <= '0;
         skipping_ff    <= 1'b1;
         line_num_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         cfg_width_ff   <= cfg_width_in;
         cfg_align_ff   <= cfg_align_in;
         cfg_attr_ff    <= cfg_attr_in;
         cfg_acc_en_ff  <= cfg_acc_en_in;
         cfg_acc_pos_ff <= cfg_acc_pos_in;
         state_ff       <= state_in;
         caption_pos_ff <= caption_pos_in;
         start_pos_ff   <= start_pos_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
         skipping_ff    <= skipping_in;
         line_num_ff    <= line_num_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      end_ff        <= end_in;
      char_pos_ff   <= char_pos_in;
      cur_pos_ff    <= cur_pos_in;
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      brk_ff        <= brk_in;
      pend_char_ff  <= pend_char_in;
      pend_col_ff   <= pend_col_in;
      pend_line_ff  <= pend_line_in;
      pend_attr_ff  <= pend_attr_in;
      pend_ldone_ff <= pend_ldone_in;
      out_char_ff   <= out_char_in;
      out_col_ff    <= out_col_in;
      out_line_ff   <= out_line_in;
      out_attr_ff   <= out_attr_in;
      out_ldone_ff  <= out_ldone_in;
      out_cdone_ff  <= out_cdone_in;
      out_last_ff   <= out_last_in;
   end

   // Ports
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_cell_char    = out_char_ff;
   assign rsp_cell_column  = out_col_ff;
   assign rsp_cell_line    = out_line_ff;
   assign rsp_cell_attr    = out_attr_ff;
   assign rsp_line_done    = out_ldone_ff;
   assign rsp_caption_done = out_cdone_ff;
   assign rsp_run_last     = out_last_ff;

endmodule

// ===== bench/tb_greedy_word_wrap_cells.sv =====
// Self-checking testbench for the caption word-wrap cell generator.
`timescale 1ns / 1ps

module tb_greedy_word_wrap_cells;
   import gww_pkg::*;

   localparam int MAX_W      = 32;
   localparam int LIMIT      = 1_000_000;
   localparam int SETTLE     = 300;

   // alignment codes the package does not name
   localparam logic [1:0] ALIGN_LEFT = 2'd0;
   localparam logic [1:0] ALIGN_ODD  = 2'd3;

   typedef struct {
      logic [CHAR_W-1:0] c;
      logic              fin;
   } caption_item_type;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  col;
      logic [LINE_W-1:0] row;
      logic [ATTR_W-1:0] attr;
      logic              line_done;
      logic              caption_done;
      logic              run_last;
   } wrap_cell_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_text_char = '0;
   logic                req_text_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_cell_char;
   logic [COL_W-1:0]    rsp_cell_column;
   logic [LINE_W-1:0]   rsp_cell_line;
   logic [ATTR_W-1:0]   rsp_cell_attr;
   logic                rsp_line_done;
   logic                rsp_caption_done;
   logic                rsp_run_last;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [4:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   greedy_word_wrap_cells dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_char    (req_text_char),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_line    (rsp_cell_line),
      .rsp_cell_attr    (rsp_cell_attr),
      .rsp_line_done    (rsp_line_done),
      .rsp_caption_done (rsp_caption_done),
      .rsp_run_last     (rsp_run_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // bench bookkeeping
   caption_item_type chars_waiting[$];
   wrap_cell_type    cells_due[$];
   wrap_cell_type    step_cells[$];
   int            queued_count = 0;
   int            taken_count = 0;
   int            cells_seen = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 16;
   int            stall_pct = 74;
   bit            req_fire = 1'b0;

   // register shadow
   logic [5:0]        w_width = RST_LINE_WIDTH;
   logic [1:0]        w_align = ALIGN_LEFT;
   logic [ATTR_W-1:0] w_attr = RST_TEXT_ATTR;
   logic              w_hilite_en = 1'b0;
   logic [ACCEL_W-1:0] w_hilite_pos = '0;

   // wrap state of the predictor
   logic [CHAR_W-1:0]  line_buf [0:MAX_W];
   int                 buf_len = 0;
   logic [ACCEL_W-1:0] buf_first_pos = '0;
   logic [ACCEL_W-1:0] char_pos = '0;
   logic               eat_blanks = 1'b1;
   logic [LINE_W-1:0]  line_idx = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic blank_char(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF;
   endfunction

   function automatic int clamp_width();
      if (w_width == 0) return 1;
      if (w_width > MAX_W) return MAX_W;
      return int'(w_width);
   endfunction

   // cells of the first len buffered characters as one displayed line
   task automatic put_line(input int len);
      int w;
      int col0;
      int i;
      logic [ACCEL_W-1:0] pos;
      wrap_cell_type c_out;
      w = clamp_width();
      col0 = 0;
      if (len <= w) begin
         if (w_align == ALIGN_RIGHT) begin
            col0 = w - len;
         end else if (w_align == ALIGN_CENTER) begin
            col0 = (w - len) / 2;
         end
      end
      for (i = 0; i < len && i <= MAX_W; i++) begin
         if (step_cells.size() >= MAX_W + 1) break;
         pos = buf_first_pos + ACCEL_W'(i);
         c_out.ch = line_buf[i];
         c_out.col = COL_W'(col0 + i);
         c_out.row = line_idx;
         c_out.attr = (w_hilite_en && pos == w_hilite_pos) ?
                      ((w_attr & ATTR_KEEP_MASK) | ATTR_HI_SET) : w_attr;
         c_out.line_done = (i + 1 == len);
         c_out.caption_done = 1'b0;
         c_out.run_last = 1'b0;
         step_cells.push_back(c_out);
      end
      if (line_idx < 8'd255) line_idx++;
   endtask

   // remove n characters from the front of the line buffer
   task automatic drop_chars(input int n);
      int i;
      if (n > buf_len) n = buf_len;
      for (i = 0; i < buf_len - n; i++) line_buf[i] = line_buf[i + n];
      buf_len -= n;
      buf_first_pos = buf_first_pos + ACCEL_W'(n);
   endtask

   // expected cells for one accepted caption character
   task automatic wrap_char(input logic [CHAR_W-1:0] c, input logic fin);
      logic [ACCEL_W-1:0] p;
      int w;
      int cut;
      int s;
      int j;
      p = char_pos;
      w = clamp_width();
      step_cells.delete();
      char_pos = p + ACCEL_W'(1);
      // a full line breaks at the last space inside the width, else at the width
      while (buf_len > 0 && buf_len >= w) begin
         cut = w;
         for (s = w - 1; s > 0; s--) begin
            if (line_buf[s] == CHAR_SPACE) begin
               cut = s;
               break;
            end
         end
         put_line(cut);
         j = cut;
         while (j < buf_len && blank_char(line_buf[j])) j++;
         drop_chars(j);
         eat_blanks = (buf_len == 0);
      end
      if (!(eat_blanks && blank_char(c))) begin
         if (c == CHAR_CR || c == CHAR_LF) begin
            if (buf_len > 0) put_line(buf_len);
            drop_chars(buf_len);
            eat_blanks = 1'b1;
         end else if (buf_len < MAX_W) begin
            if (buf_len == 0) buf_first_pos = p;
            line_buf[buf_len] = c;
            buf_len++;
            eat_blanks = 1'b0;
         end
      end
      if (fin) begin
         if (buf_len > 0) put_line(buf_len);
         if (step_cells.size() > 0) step_cells[$].caption_done = 1'b1;
         buf_len = 0;
         buf_first_pos = '0;
         char_pos = '0;
         eat_blanks = 1'b1;
         line_idx = '0;
      end
      if (step_cells.size() > 0) step_cells[$].run_last = 1'b1;
      foreach (step_cells[k]) cells_due.push_back(step_cells[k]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: cell %0d %s expected %0h got %0h", $time, cells_seen, name, want, got);
         fail_count++;
      end
   endtask

   // result checking and prediction at the rising edge
   always @(posedge clock) begin : watch
      wrap_cell_type want;
      cycle_count++;
      req_fire = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cells_due.size() == 0) begin
            $display("%0t: unexpected cell char %h column %0d line %0d", $time,
                     rsp_cell_char, rsp_cell_column, rsp_cell_line);
            fail_count++;
         end else begin
            want = cells_due.pop_front();
            check_field("char", want.ch, rsp_cell_char);
            check_field("column", want.col, rsp_cell_column);
            check_field("line", want.row, rsp_cell_line);
            check_field("attr", want.attr, rsp_cell_attr);
            check_field("line_done", want.line_done, rsp_line_done);
            check_field("caption_done", want.caption_done, rsp_caption_done);
            check_field("run_last", want.run_last, rsp_run_last);
         end
         cells_seen++;
      end
      if (req_fire) begin
         wrap_char(req_text_char, req_text_end);
         taken_count++;
      end
   end

   // character driver and result stall at the falling edge
   always @(negedge clock) begin : feed
      caption_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (chars_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = chars_waiting.pop_front();
               req_valid <= 1'b1;
               req_text_char <= nxt.c;
               req_text_end <= nxt.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic add_char(input logic [CHAR_W-1:0] c, input logic fin);
      caption_item_type it;
      it.c = c;
      it.fin = fin;
      chars_waiting.push_back(it);
      queued_count++;
   endtask

   task automatic add_text(input string s, input logic fin);
      int i;
      for (i = 0; i < s.len(); i++) add_char(CHAR_W'(s[i]), fin && i == s.len() - 1);
   endtask

   function automatic logic [CHAR_W-1:0] blank_pick();
      case ($urandom_range(2))
         0: return CHAR_SPACE;
         1: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // wait until every character is taken and every cell has come back
   task automatic drain();
      while (taken_count != queued_count || cells_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_LINE_WIDTH:   w_width = val[5:0];
         REG_TEXT_ALIGN:   w_align = val[1:0];
         REG_TEXT_ATTR:    w_attr = val[ATTR_W-1:0];
         REG_ACCEL_ENABLE: w_hilite_en = val[0];
         REG_ACCEL_POS:    w_hilite_pos = val[ACCEL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic setup(input int width, input logic [1:0] align, input logic [15:0] attr,
                        input logic hl_en, input int hl_pos);
      csr_write(REG_LINE_WIDTH, width);
      csr_write(REG_TEXT_ALIGN, 32'(align));
      csr_write(REG_TEXT_ATTR, 32'(attr));
      csr_write(REG_ACCEL_ENABLE, 32'(hl_en));
      csr_write(REG_ACCEL_POS, hl_pos);
   endtask

   task automatic random_setup();
      int width;
      int hl_pos;
      width = ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(4, 32);
      hl_pos = ($urandom_range(7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 60);
      setup(width, 2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)), hl_pos);
   endtask

   // one random caption of at most room characters: mostly words and separators,
   // sometimes raw noise
   task automatic queue_caption(input int room);
      logic [CHAR_W-1:0] txt[$];
      logic [CHAR_W-1:0] ch;
      int words;
      int len;
      int i;
      int pick;
      if ($urandom_range(7) == 0) begin
         len = $urandom_range(1, 24);
         if (len > room) len = room;
         for (i = 0; i < len; i++) begin
            ch = ($urandom_range(5) < 3) ? blank_pick() : CHAR_W'($urandom);
            add_char(ch, $urandom_range(19) == 0);
         end
         return;
      end
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) txt.push_back(blank_pick());
      end
      words = $urandom_range(1, 8);
      for (i = 0; i < words; i++) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
         repeat (len) begin
            if ($urandom_range(9) == 0) txt.push_back(CHAR_W'($urandom));
            else txt.push_back(16'h0061 + CHAR_W'($urandom_range(25)));
         end
         pick = $urandom_range(11);
         if (i < words - 1 || pick >= 8) begin
            case (pick)
               7: begin
                  txt.push_back(CHAR_SPACE);
                  txt.push_back(CHAR_SPACE);
               end
               8: txt.push_back(CHAR_CR);
               9: txt.push_back(CHAR_LF);
               10: begin
                  txt.push_back(CHAR_CR);
                  txt.push_back(CHAR_LF);
               end
               11: begin
                  txt.push_back(CHAR_SPACE);
                  txt.push_back(CHAR_SPACE);
                  txt.push_back(CHAR_LF);
               end
               default: txt.push_back(CHAR_SPACE);
            endcase
         end
      end
      if (txt.size() > room) txt = txt[0:room-1];
      foreach (txt[k]) add_char(txt[k], k == txt.size() - 1);
   endtask

   task automatic queue_items(input int n);
      int target;
      target = queued_count + n;
      while (queued_count < target) queue_caption(target - queued_count);
   endtask

   // a run of halves, with a full stop for all cells in between
   task automatic random_phase(input int width, input logic [1:0] align,
                               input logic [15:0] attr, input int hl_pos);
      setup(width, align, attr, 1'b1, hl_pos);
      queue_items(30);
      drain();
      random_setup();
      queue_items(30);
      drain();
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // leading blanks, highlight on a dropped char, trailing spaces,
      // repeated breaks, break at a space
      setup(6, ALIGN_CENTER, 16'hA5C3, 1'b1, 1);
      add_char(CHAR_SPACE, 1'b0);
      add_char(CHAR_LF, 1'b0);
      add_char("a", 1'b0);
      add_char(16'hFFFF, 1'b0);
      add_char(CHAR_SPACE, 1'b0);
      add_char(CHAR_CR, 1'b0);
      add_char(CHAR_CR, 1'b0);
      add_text("x yzwu", 1'b0);
      add_char("v", 1'b1);
      drain();

      // clamped width and odd alignment, then width lowered mid-line
      csr_write(REG_LINE_WIDTH, 40);
      csr_write(REG_TEXT_ALIGN, 32'(ALIGN_ODD));
      add_text("abcde fgh", 1'b0);
      drain();
      csr_write(REG_LINE_WIDTH, 2);
      csr_write(REG_ACCEL_ENABLE, 32'd0);
      add_char("i", 1'b1);

      // caption end with nothing left to show
      add_char(16'h0000, 1'b0);
      add_char(CHAR_LF, 1'b0);
      add_char(CHAR_CR, 1'b1);
      drain();

      random_phase(0, ALIGN_RIGHT, 16'h0000, 3);

      send_idle_pct = 74;
      stall_pct = 16;
      random_phase(63, ALIGN_CENTER, 16'hFFFF, 4095);

      send_idle_pct = 0;
      stall_pct = 0;
      random_phase(32, ALIGN_LEFT, 16'h5AF0, 0);

      if (fail_count == 0) begin
         $display("** greedy_word_wrap_cells: PASSED **");
      end else begin
         $display("** greedy_word_wrap_cells: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < LIMIT) @(posedge clock);
      $display("%0t: run limit reached, %0d cells still due", $time, cells_due.size());
      $display("** greedy_word_wrap_cells: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gww_pkg.sv
hw/rtl/gww_line_buf.sv
hw/rtl/greedy_word_wrap_cells.sv
bench/tb_greedy_word_wrap_cells.sv
